// File: hw/rtl/process_state_queue_manager_defines.svh
// Assertion macros used by the process state queue manager top level.
`ifndef PROCESS_STATE_QUEUE_MANAGER_DEFINES_SVH
`define PROCESS_STATE_QUEUE_MANAGER_DEFINES_SVH

// Same-cycle implication, checked at every rising clk outside reset.
`define PSQM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk outside reset.
`define PSQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/psqm_pkg.sv
// Shared types and constants of the process state queue manager.
package psqm_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int NUM_Q        = 3;
  localparam int ID_W         = 16;
  localparam int REC_W        = 2 * ID_W;
  localparam int CNT_OUT_W    = 5;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 56;

  typedef logic [1:0] qsel_t;

  localparam qsel_t Q_READY = 2'd0;
  localparam qsel_t Q_RUN   = 2'd1;
  localparam qsel_t Q_WAIT  = 2'd2;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_EXECUTE = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_WAKE    = 3'd3,
    CMD_BLOCK   = 3'd4,
    CMD_RUN     = 3'd5,
    CMD_CLEAR   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Pointer/count update request from the sequencer to the queue state.
  typedef struct packed {
    logic  clear;
    logic  push_en;
    qsel_t push_q;
    logic  pop_en;
    qsel_t pop_q;
  } qupd_t;

endpackage

// File: hw/rtl/process_state_queue_manager.sv
// Process state queue manager: top level with command sequencer and result register.
//
// Keeps three FIFO queues of process records (ready, running, waiting), each
// in its own CAPACITY-deep, 32-bit synchronous RAM. A request is handled in
// states S_IDLE and S_WORK: in the accept cycle the head entry of every queue
// is read; in S_WORK the sequencer checks counts, writes the moved or created
// record into the tail of its destination RAM, updates heads/tails/counts and
// loads the result register. The next request is accepted in the cycle after
// that write-back, so a new request is taken only once the last one is done;
// the write-back cycle waits as long as a previous result still sits
// unclaimed in the output register. Source and destination of a move are
// always different RAMs and requests do not overlap, so no forwarding is
// needed. RAM contents are not cleared at reset: counts gate every read, so
// the block is ready right out of reset. Counts are reported as 5 bits.
module process_state_queue_manager #(
  parameter int CAPACITY = psqm_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] cmd, [18:3] proc_id, [34:19] user_id, [39:35] zero
  input  logic [psqm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] status, [17:2] moved_proc_id, [33:18] moved_user_id,
  // [38:34] ready_count, [43:39] running_count, [48:44] waiting_count,
  // [55:49] zero
  output logic [psqm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import psqm_pkg::*;

`include "process_state_queue_manager_defines.svh"

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 2;

  typedef enum logic {S_IDLE, S_WORK} state_t;

  state_t            state_r;
  cmd_t              cmd_r;
  logic [ID_W-1:0]   pid_r;
  logic [ID_W-1:0]   uid_r;
  logic              out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [NUM_Q-1:0][IDX_W-1:0] heads, tails;
  logic [NUM_Q-1:0][CNT_W-1:0] counts, counts_nxt;
  logic [REC_W-1:0]            rd_rec [NUM_Q];

  logic        in_fire;
  logic        slot_free;
  logic        fire;
  qupd_t       upd;
  status_t     res_status;
  logic [REC_W-1:0] res_rec;
  qsel_t       src_q;
  logic        src_empty;
  logic [SUM_W-1:0] total;
  logic        full;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign fire      = (state_r == S_WORK) && slot_free;

  // Queue pointers and counts
  psqm_qstate #(.CAPACITY(CAPACITY)) u_qstate (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (fire),
    .upd        (upd),
    .heads      (heads),
    .tails      (tails),
    .counts     (counts),
    .counts_nxt (counts_nxt)
  );

  // One RAM per queue; every head is read on accept, the chosen one is used in S_WORK.
  for (genvar q = 0; q < NUM_Q; q++) begin : g_store
    psqm_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
      .clk   (clk),
      .we    (fire && upd.push_en && upd.push_q == qsel_t'(q)),
      .waddr (tails[q]),
      .wdata (res_rec),
      .re    (in_fire),
      .raddr (heads[q]),
      .rdata (rd_rec[q])
    );
  end

  always_comb begin
    case (cmd_r)
      CMD_EXECUTE: src_q = Q_READY;
      CMD_WAKE:    src_q = Q_WAIT;
      default:     src_q = Q_RUN;
    endcase
  end

  assign src_empty = (counts[src_q] == '0);
  assign total     = SUM_W'(counts[Q_READY]) + SUM_W'(counts[Q_RUN]) + SUM_W'(counts[Q_WAIT]);
  assign full      = (total >= SUM_W'(CAPACITY));

  // Command decode: status, record and queue update for the write-back cycle
  always_comb begin
    upd        = '0;
    res_status = ST_DONE;
    res_rec    = '0;
    case (cmd_r)
      CMD_CREATE: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_rec     = {uid_r, pid_r};
          upd.push_en = 1'b1;
          upd.push_q  = Q_READY;
        end
      end
      CMD_EXECUTE, CMD_SUSPEND, CMD_WAKE, CMD_BLOCK, CMD_RUN: begin
        if (src_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_rec    = rd_rec[src_q];
          upd.pop_en = 1'b1;
          upd.pop_q  = src_q;
          if (cmd_r != CMD_RUN) begin
            upd.push_en = 1'b1;
            upd.push_q  = (cmd_r == CMD_EXECUTE) ? Q_RUN :
                          (cmd_r == CMD_BLOCK)   ? Q_WAIT : Q_READY;
          end
        end
      end
      CMD_CLEAR: begin
        upd.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_WORK;
          end
        end
        S_WORK: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_tdata[2:0]);
      pid_r <= in_tdata[18:3];
      uid_r <= in_tdata[34:19];
    end
    if (fire) begin
      out_tdata_r <= {7'd0,
                      CNT_OUT_W'(counts_nxt[Q_WAIT]),
                      CNT_OUT_W'(counts_nxt[Q_RUN]),
                      CNT_OUT_W'(counts_nxt[Q_READY]),
                      res_rec,
                      res_status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PSQM_ASSERT_NOW(a_total_in_capacity, 1'b1, total <= SUM_W'(CAPACITY), "queue total above capacity")
  `PSQM_ASSERT_NEXT(a_accept_to_work, in_fire, state_r == S_WORK, "accepted request not in work")
  `PSQM_ASSERT_NOW(a_fail_no_record, out_tvalid && out_tdata[1:0] != ST_DONE, out_tdata[33:2] == '0, "record reported on failed request")
  `PSQM_ASSERT_NEXT(a_clear_empties, fire && cmd_r == CMD_CLEAR, counts == '0, "clear left records behind")

endmodule

// File: hw/rtl/psqm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module psqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/psqm_qstate.sv
// Head, tail and count registers of the three process queues.
module psqm_qstate #(
  parameter int CAPACITY = psqm_pkg::CAPACITY_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                upd_en,
  input  psqm_pkg::qupd_t                                     upd,
  output logic [psqm_pkg::NUM_Q-1:0][$clog2(CAPACITY)-1:0]    heads,
  output logic [psqm_pkg::NUM_Q-1:0][$clog2(CAPACITY)-1:0]    tails,
  output logic [psqm_pkg::NUM_Q-1:0][$clog2(CAPACITY+1)-1:0]  counts,
  output logic [psqm_pkg::NUM_Q-1:0][$clog2(CAPACITY+1)-1:0]  counts_nxt
);
  import psqm_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [NUM_Q-1:0][IDX_W-1:0] heads_r, heads_nxt;
  logic [NUM_Q-1:0][IDX_W-1:0] tails_r, tails_nxt;
  logic [NUM_Q-1:0][CNT_W-1:0] counts_r;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    heads_nxt  = heads_r;
    tails_nxt  = tails_r;
    counts_nxt = counts_r;
    if (upd_en) begin
      if (upd.clear) begin
        heads_nxt  = '0;
        tails_nxt  = '0;
        counts_nxt = '0;
      end else begin
        for (int q = 0; q < NUM_Q; q++) begin
          if (upd.push_en && upd.push_q == qsel_t'(q)) begin
            tails_nxt[q]  = wrap_inc(tails_r[q]);
            counts_nxt[q] = counts_r[q] + 1'b1;
          end
          if (upd.pop_en && upd.pop_q == qsel_t'(q)) begin
            heads_nxt[q]  = wrap_inc(heads_r[q]);
            counts_nxt[q] = counts_r[q] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r  <= '0;
      tails_r  <= '0;
      counts_r <= '0;
    end else begin
      heads_r  <= heads_nxt;
      tails_r  <= tails_nxt;
      counts_r <= counts_nxt;
    end
  end

  assign heads  = heads_r;
  assign tails  = tails_r;
  assign counts = counts_r;

endmodule

// File: sim/process_state_queue_manager_tb.sv
// Self-checking testbench for the process state queue manager stream block.
module process_state_queue_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psqm_pkg::*;

  localparam int          CAP        = CAPACITY_DEF;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;     // no-op code, block must ignore it
  localparam int          RANDOM_ITEMS = 1200;

  // traffic shapes for the random part
  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_BALANCE = 2;

  typedef struct packed {
    logic [ID_W-1:0] uid;
    logic [ID_W-1:0] pid;
  } proc_rec_t;

  typedef struct {
    status_t              status;
    logic [ID_W-1:0]      pid;
    logic [ID_W-1:0]      uid;
    logic [CNT_OUT_W-1:0] ready_cnt;
    logic [CNT_OUT_W-1:0] running_cnt;
    logic [CNT_OUT_W-1:0] waiting_cnt;
  } queue_status_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the three process queues
  proc_rec_t ready_q[$];
  proc_rec_t running_q[$];
  proc_rec_t waiting_q[$];

  // expected responses, oldest first
  queue_status_t pending_status[$];

  int unsigned mismatches;
  int unsigned responses_seen;
  bit          in_idle_en;
  bit          out_idle_en;
  int          hold_cycles;      // one-shot long backpressure, consumed by the receiver

  process_state_queue_manager u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Update the shadow queues for one accepted command and return the response
  // the block owes for it.
  function automatic queue_status_t apply_command(logic [2:0] cmd, logic [ID_W-1:0] pid,
                                                  logic [ID_W-1:0] uid);
    queue_status_t r;
    proc_rec_t     rec;
    rec      = '0;
    r.status = ST_DONE;
    case (cmd)
      CMD_CREATE: begin
        // capacity covers all three queues together
        if (ready_q.size() + running_q.size() + waiting_q.size() >= CAP) begin
          r.status = ST_FULL;
        end else begin
          rec = {uid, pid};
          ready_q.push_back(rec);
        end
      end
      CMD_EXECUTE: begin
        if (ready_q.size() != 0) begin
          rec = ready_q.pop_front();
          running_q.push_back(rec);
        end else r.status = ST_EMPTY;
      end
      CMD_SUSPEND: begin
        if (running_q.size() != 0) begin
          rec = running_q.pop_front();
          ready_q.push_back(rec);
        end else r.status = ST_EMPTY;
      end
      CMD_WAKE: begin
        if (waiting_q.size() != 0) begin
          rec = waiting_q.pop_front();
          ready_q.push_back(rec);
        end else r.status = ST_EMPTY;
      end
      CMD_BLOCK: begin
        if (running_q.size() != 0) begin
          rec = running_q.pop_front();
          waiting_q.push_back(rec);
        end else r.status = ST_EMPTY;
      end
      CMD_RUN: begin
        // retired record leaves the block
        if (running_q.size() != 0) rec = running_q.pop_front();
        else r.status = ST_EMPTY;
      end
      CMD_CLEAR: begin
        ready_q.delete();
        running_q.delete();
        waiting_q.delete();
      end
      default: ;
    endcase
    r.pid         = rec.pid;
    r.uid         = rec.uid;
    r.ready_cnt   = CNT_OUT_W'(ready_q.size());
    r.running_cnt = CNT_OUT_W'(running_q.size());
    r.waiting_cnt = CNT_OUT_W'(waiting_q.size());
    return r;
  endfunction

  // Offer one request, after a random gap if idle gaps are on; returns once it is accepted.
  task automatic send_request(logic [2:0] cmd, logic [ID_W-1:0] pid, logic [ID_W-1:0] uid);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, uid, pid, cmd};
    do @(posedge clk); while (!in_tready);
    pending_status.push_back(apply_command(cmd, pid, uid));
  endtask

  function automatic logic [ID_W-1:0] random_id();
    // extremes show up often enough to matter
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [2:0] pick_command(int mode);
    int roll;
    int create_pct;
    int run_pct;
    roll       = $urandom_range(0, 99);
    create_pct = (mode == MODE_FILL) ? 45 : (mode == MODE_DRAIN) ? 10 : 28;
    run_pct    = (mode == MODE_DRAIN) ? 25 : 8;
    if (roll < 2) return CMD_CLEAR;
    if (roll < 4) return CMD_UNUSED;
    if (roll < 4 + create_pct) return CMD_CREATE;
    if (roll < 4 + create_pct + run_pct) return CMD_RUN;
    return 3'($urandom_range(CMD_EXECUTE, CMD_BLOCK));
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in response %0d: %s expected 0x%0h got 0x%0h",
                 responses_seen, field, want, got);
    end
  endtask

  // Response checker: every accepted response against the oldest expectation.
  always @(posedge clk) begin
    queue_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response %0d: tdata 0x%0h", responses_seen, out_tdata);
      end else begin
        want = pending_status.pop_front();
        check_field("status",        want.status,      out_tdata[1:0]);
        check_field("moved_proc_id", want.pid,         out_tdata[17:2]);
        check_field("moved_user_id", want.uid,         out_tdata[33:18]);
        check_field("ready_count",   want.ready_cnt,   out_tdata[38:34]);
        check_field("running_count", want.running_cnt, out_tdata[43:39]);
        check_field("waiting_count", want.waiting_cnt, out_tdata[48:44]);
      end
      responses_seen++;
    end
  end

  // Receiver: random stall before each response, plus a one-shot long hold.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = out_idle_en ? $urandom_range(0, 5) : 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Every source queue empty, plus the ignored code.
  task automatic test_empty_sources();
    send_request(CMD_RUN,     random_id(), random_id());
    send_request(CMD_EXECUTE, random_id(), random_id());
    send_request(CMD_SUSPEND, random_id(), random_id());
    send_request(CMD_WAKE,    random_id(), random_id());
    send_request(CMD_BLOCK,   random_id(), random_id());
    send_request(CMD_UNUSED,  16'hffff,    16'hffff);
  endtask

  // Walk records through every transition, id extremes included.
  task automatic test_each_command();
    send_request(CMD_CREATE,  16'h0000, 16'h0000);
    send_request(CMD_CREATE,  16'hffff, 16'hffff);
    send_request(CMD_CREATE,  16'ha5a5, 16'h5a5a);
    send_request(CMD_EXECUTE, 16'hffff, 16'hffff);   // ids ignored off create
    send_request(CMD_EXECUTE, random_id(), random_id());
    send_request(CMD_BLOCK,   random_id(), random_id());
    send_request(CMD_SUSPEND, random_id(), random_id());
    send_request(CMD_WAKE,    random_id(), random_id());
    send_request(CMD_RUN,     random_id(), random_id());
    send_request(CMD_UNUSED,  random_id(), random_id());
    send_request(CMD_CLEAR,   random_id(), random_id());
    send_request(CMD_EXECUTE, random_id(), random_id()); // empty again after clear
  endtask

  // Fill to capacity, refuse the next create, even with records spread out.
  task automatic test_fill_to_capacity();
    repeat (CAP) send_request(CMD_CREATE, random_id(), random_id());
    send_request(CMD_CREATE,  random_id(), random_id());
    send_request(CMD_EXECUTE, random_id(), random_id());
    send_request(CMD_EXECUTE, random_id(), random_id());
    send_request(CMD_BLOCK,   random_id(), random_id());
    send_request(CMD_CREATE,  random_id(), random_id());
    send_request(CMD_RUN,     random_id(), random_id());
    send_request(CMD_CREATE,  random_id(), random_id());
    send_request(CMD_CLEAR,   random_id(), random_id());
    send_request(CMD_CREATE,  random_id(), random_id());
  endtask

  // Long output hold while requests keep coming, so the input side backs up.
  task automatic test_output_backpressure();
    in_idle_en  = 1'b0;
    hold_cycles = 300;
    repeat (30) send_request(pick_command(MODE_BALANCE), random_id(), random_id());
    in_idle_en  = 1'b1;
  endtask

  // Random traffic in blocks, each with its own mix and idle pattern.
  task automatic test_random_traffic(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        mode        = $urandom_range(MODE_FILL, MODE_BALANCE);
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_request(pick_command(mode), random_id(), random_id());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    mismatches     = 0;
    responses_seen = 0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    hold_cycles    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_sources();
    test_each_command();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    in_tvalid <= 1'b0;

    // drain, then wait for any stray response to show
    while (pending_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS process_state_queue_manager");
    end else begin
      $display("FAIL process_state_queue_manager");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL process_state_queue_manager");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/psqm_pkg.sv
hw/rtl/psqm_ram.sv
hw/rtl/psqm_qstate.sv
hw/rtl/process_state_queue_manager.sv
sim/process_state_queue_manager_tb.sv
